// File: hw/rtl/ewald_excluded_pair_cross_energy_assert.svh
// Assertion macros shared by the excluded-pair energy RTL.
// Each macro samples on aclk and is disabled while aresetn is low.
`ifndef EWALD_EXCLUDED_PAIR_CROSS_ENERGY_ASSERT_SVH
`define EWALD_EXCLUDED_PAIR_CROSS_ENERGY_ASSERT_SVH

// Same-cycle implication
`define EEPCE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define EEPCE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/eepce_pkg.sv
// Package for the excluded-pair energy block: constants, codes, command
// and status types, and the erf table builder. No dependencies.
`timescale 1ns / 1ps
package eepce_pkg;

    localparam int ERF_N        = 1024;
    localparam int ERF_SUBSTEPS = 16;
    localparam int ERF_SPAN     = ERF_N * ERF_SUBSTEPS;
    localparam int ERF_AW       = $clog2(ERF_N + 1);

    localparam logic [63:0] ONE_Q30         = 64'h0000_0000_4000_0000;
    localparam logic [63:0] INV_SQRT_PI_Q24 = 64'd9465531;
    localparam logic [31:0] BETA_RESET      = 32'd80530637;

    localparam logic signed [49:0] ACC_MAX = 50'sd140737488355327;
    localparam logic signed [49:0] ACC_MIN = -50'sd140737488355328;
    localparam logic [48:0]        MAG_CAP = 49'h1_0000_0000_0000;

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_X = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_Y = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_Z = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BETA  = 8'd3;

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 55;
    localparam int CNT_W      = 6;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_AXIS,
        OP_SQUARE,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_BETA,
        OP_ROM_LO,
        OP_ROM_HI,
        OP_INTERP,
        OP_DIV_STEP,
        OP_MUL,
        OP_ACC,
        OP_EMIT
    } dp_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AXIS,
        ST_SQUARE,
        ST_SQRT_INIT,
        ST_SQRT,
        ST_BETA,
        ST_ROM_LO,
        ST_ROM_HI,
        ST_INTERP,
        ST_DIV,
        ST_MUL,
        ST_ACC,
        ST_FINISH
    } ctl_state_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] sel;
    } dp_cmd_t;

    typedef struct packed {
        logic r_zero;
        logic last;
        logic out_full;
    } dp_status_t;

    typedef logic [31:0] erf_tab_t [0:ERF_N];

    // Divide by a small loop constant, one literal divisor per arm
    function automatic logic [63:0] div_small(input logic [63:0] v, input int k);
        logic [63:0] q;
        case (k)
            2: q = v / 2;
            3: q = v / 3;
            4: q = v / 4;
            5: q = v / 5;
            6: q = v / 6;
            7: q = v / 7;
            8: q = v / 8;
            default: q = v;
        endcase
        return q;
    endfunction

    // exp(-y), y in Q.32, result Q1.31
    function automatic logic [63:0] exp_neg(input logic [63:0] y);
        logic [63:0] z;
        logic [63:0] r;
        int k;
        if (y >= (64'd32 << 32)) begin
            return 64'd0;
        end
        z = y >> 7;
        r = 64'd1 << 31;
        for (k = 8; k >= 1; k--) begin
            r = (64'd1 << 31) - div_small((z * r) >> 31, k);
        end
        for (k = 0; k < 6; k++) begin
            r = (r * r) >> 31;
        end
        return r;
    endfunction

    // Trapezoid integration of the erf integrand, Q1.30 samples
    function automatic erf_tab_t build_erf_tab();
        erf_tab_t tab;
        logic [63:0] s;
        logic [63:0] gprev;
        logic [63:0] t;
        logic [63:0] g;
        logic [63:0] v;
        logic [63:0] e;
        int m;
        s      = 64'd0;
        gprev  = 64'd1 << 31;
        tab[0] = 32'd0;
        for (m = 1; m <= ERF_SPAN; m++) begin
            t     = (64'(m) << 31) / ERF_SPAN;
            g     = exp_neg((t * t) >> 24);
            s     = s + gprev + g;
            gprev = g;
            if (m % ERF_SUBSTEPS == 0) begin
                v = (s << 8) / ERF_SPAN;
                e = (v * INV_SQRT_PI_Q24) >> 30;
                if (e > ONE_Q30) begin
                    e = ONE_Q30;
                end
                tab[m / ERF_SUBSTEPS] = e[31:0];
            end
        end
        return tab;
    endfunction

    localparam erf_tab_t ERF_TAB = build_erf_tab();

endpackage

// File: hw/rtl/eepce_ctrl.sv
// Sequencer for the excluded-pair energy block.
// Depends on eepce_pkg; drives the datapath through dp_cmd_t.
`timescale 1ns / 1ps
`include "ewald_excluded_pair_cross_energy_assert.svh"
module eepce_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  eepce_pkg::dp_status_t status,
    output eepce_pkg::dp_cmd_t    cmd
);
    import eepce_pkg::*;

    ctl_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // State and step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg + CNT_W'(1);
        case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (s_valid) state_next = ST_AXIS;
            end
            ST_AXIS: begin
                if (cnt_reg == CNT_W'(2)) begin
                    state_next = ST_SQUARE;
                    cnt_next   = '0;
                end
            end
            ST_SQUARE: begin
                if (cnt_reg == CNT_W'(2)) state_next = ST_SQRT_INIT;
            end
            ST_SQRT_INIT: begin
                state_next = ST_SQRT;
                cnt_next   = '0;
            end
            ST_SQRT: begin
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1)) state_next = ST_BETA;
            end
            ST_BETA: begin
                state_next = status.r_zero ? ST_FINISH : ST_ROM_LO;
            end
            ST_ROM_LO: state_next = ST_ROM_HI;
            ST_ROM_HI: state_next = ST_INTERP;
            ST_INTERP: begin
                state_next = ST_DIV;
                cnt_next   = '0;
            end
            ST_DIV: begin
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_MUL;
                    cnt_next   = '0;
                end
            end
            ST_MUL: begin
                if (cnt_reg == CNT_W'(3)) state_next = ST_ACC;
            end
            ST_ACC: state_next = ST_FINISH;
            ST_FINISH: begin
                if (!status.last || !status.out_full) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        s_ready = 1'b0;
        cmd.sel = cnt_reg[1:0];
        cmd.op  = OP_NONE;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) cmd.op = OP_LOAD;
            end
            ST_AXIS:      cmd.op = OP_AXIS;
            ST_SQUARE:    cmd.op = OP_SQUARE;
            ST_SQRT_INIT: cmd.op = OP_SQRT_INIT;
            ST_SQRT:      cmd.op = OP_SQRT_STEP;
            ST_BETA:      cmd.op = OP_BETA;
            ST_ROM_LO:    cmd.op = OP_ROM_LO;
            ST_ROM_HI:    cmd.op = OP_ROM_HI;
            ST_INTERP:    cmd.op = OP_INTERP;
            ST_DIV:       cmd.op = OP_DIV_STEP;
            ST_MUL:       cmd.op = OP_MUL;
            ST_ACC:       cmd.op = OP_ACC;
            ST_FINISH: begin
                if (status.last && !status.out_full) cmd.op = OP_EMIT;
            end
            default: cmd.op = OP_NONE;
        endcase
    end

    `EEPCE_ASSERT_NEXT(a_sqrt_done, (state_reg == ST_SQRT && cnt_reg == CNT_W'(SQRT_STEPS - 1)), (state_reg == ST_BETA), "root did not finish after its last step")
    `EEPCE_ASSERT_NEXT(a_div_done, (state_reg == ST_DIV && cnt_reg == CNT_W'(DIV_STEPS - 1)), (state_reg == ST_MUL), "division did not hand over to the multiply")
    `EEPCE_ASSERT_NEXT(a_hold_result, (state_reg == ST_FINISH && status.last && status.out_full), (state_reg == ST_FINISH), "left finish while the result register was full")
    `EEPCE_ASSERT_NOW(a_load_idle, (cmd.op == OP_LOAD), (s_valid && s_ready), "load issued without an accepted transaction")

endmodule

// File: hw/rtl/eepce_datapath.sv
// Datapath for the excluded-pair energy block: registers, shared
// multiplier steps, iterative root and divider, erf ROM, accumulator.
// Depends on eepce_pkg.
`timescale 1ns / 1ps
module eepce_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [eepce_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                      cfg_wdata,
    input  logic [15:0]                      s_atom_index,
    input  logic [31:0]                      s_pos_i_x,
    input  logic [31:0]                      s_pos_i_y,
    input  logic [31:0]                      s_pos_i_z,
    input  logic signed [23:0]               s_charge_i,
    input  logic signed [23:0]               s_dcharge_i,
    input  logic [31:0]                      s_pos_j_x,
    input  logic [31:0]                      s_pos_j_y,
    input  logic [31:0]                      s_pos_j_z,
    input  logic signed [23:0]               s_charge_j,
    input  logic signed [23:0]               s_dcharge_j,
    input  logic                             s_last_pair,
    input  eepce_pkg::dp_cmd_t               cmd,
    output eepce_pkg::dp_status_t            status,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [15:0]                      m_atom_index_out,
    output logic signed [47:0]               m_atom_energy
);
    import eepce_pkg::*;

    logic [31:0] box_x_reg, box_y_reg, box_z_reg, beta_reg;

    logic [15:0] idx_reg;
    logic [31:0] pix_reg, piy_reg, piz_reg, pjx_reg, pjy_reg, pjz_reg;
    logic        last_reg;
    logic signed [47:0] p1_reg, p2_reg;
    logic signed [48:0] coef_reg;
    logic [47:0] cmag_reg;
    logic        neg_reg;

    logic [31:0] axis_reg [0:2];
    logic [63:0] r2_reg;
    logic [63:0] v_reg, res_reg, bit_reg;
    logic [43:0] x_reg;
    logic [31:0] rom_q_reg, t0_reg;
    logic [31:0] rem_reg;
    logic [54:0] nq_reg;
    logic [101:0] prod_reg;
    logic signed [47:0] acc_reg, acc_next;
    logic        m_valid_reg;
    logic [15:0] out_idx_reg;
    logic signed [47:0] out_energy_reg;

    logic [31:0] box_sel, pi_sel, pj_sel, diff, dmag;
    logic [63:0] axis_prod, sq, sum_rb, beta_prod, pos;
    logic [28:0] tab_idx;
    logic        tab_hit;
    logic [ERF_AW-1:0] rom_addr;
    logic [15:0] frac;
    logic [30:0] dd, erf_val;
    logic [46:0] dd_prod;
    logic [32:0] div_t;
    logic        div_ge;
    logic [31:0] mul_a, mul_b;
    logic [63:0] pp;
    logic [101:0] pp_shift;
    logic [63:0] mag_raw;
    logic [48:0] mag;
    logic signed [49:0] acc_sum;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_x_reg <= '0;
            box_y_reg <= '0;
            box_z_reg <= '0;
            beta_reg  <= BETA_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_BOX_X: box_x_reg <= cfg_wdata;
                REG_BOX_Y: box_y_reg <= cfg_wdata;
                REG_BOX_Z: box_z_reg <= cfg_wdata;
                REG_BETA:  beta_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Per-axis wrapped difference and scaling
    always_comb begin
        case (cmd.sel)
            2'd1: begin box_sel = box_y_reg; pi_sel = piy_reg; pj_sel = pjy_reg; end
            2'd2: begin box_sel = box_z_reg; pi_sel = piz_reg; pj_sel = pjz_reg; end
            default: begin box_sel = box_x_reg; pi_sel = pix_reg; pj_sel = pjx_reg; end
        endcase
        diff      = pj_sel - pi_sel;
        dmag      = diff[31] ? (~diff + 32'd1) : diff;
        axis_prod = 64'(box_sel) * 64'(dmag);
        sq        = 64'(axis_reg[cmd.sel]) * 64'(axis_reg[cmd.sel]);
        sum_rb    = res_reg + bit_reg;
    end

    // Erf lookup address and interpolation
    always_comb begin
        beta_prod = 64'(beta_reg) * 64'(res_reg[31:0]);
        pos       = {20'd0, x_reg} * 64'(ERF_N);
        tab_idx   = pos[63:35];
        tab_hit   = tab_idx < 29'(ERF_N);
        frac      = pos[34:19];
        if (cmd.op == OP_ROM_HI) begin
            rom_addr = tab_hit ? tab_idx[ERF_AW-1:0] + ERF_AW'(1) : '0;
        end else begin
            rom_addr = tab_hit ? tab_idx[ERF_AW-1:0] : '0;
        end
        dd      = (rom_q_reg[30:0] >= t0_reg[30:0]) ? rom_q_reg[30:0] - t0_reg[30:0]
                                                    : t0_reg[30:0] - rom_q_reg[30:0];
        dd_prod = 47'(dd) * 47'(frac);
        if (!tab_hit) begin
            erf_val = ONE_Q30[30:0];
        end else if (rom_q_reg[30:0] >= t0_reg[30:0]) begin
            erf_val = t0_reg[30:0] + dd_prod[46:16];
        end else begin
            erf_val = t0_reg[30:0] - dd_prod[46:16];
        end
    end

    // Divider step, partial products and saturating accumulate
    always_comb begin
        div_t  = {rem_reg, nq_reg[54]};
        div_ge = div_t >= {1'b0, res_reg[31:0]};
        mul_a  = cmd.sel[1] ? {16'd0, cmag_reg[47:32]} : cmag_reg[31:0];
        mul_b  = cmd.sel[0] ? {9'd0, nq_reg[54:32]} : nq_reg[31:0];
        pp     = 64'(mul_a) * 64'(mul_b);
        case (cmd.sel)
            2'd0:    pp_shift = 102'(pp);
            2'd3:    pp_shift = 102'(pp) << 64;
            default: pp_shift = 102'(pp) << 32;
        endcase
        mag_raw = prod_reg[101:38];
        mag     = (mag_raw > 64'(MAG_CAP)) ? MAG_CAP : mag_raw[48:0];
        if (neg_reg) begin
            acc_sum = 50'(acc_reg) + $signed({1'b0, mag});
        end else begin
            acc_sum = 50'(acc_reg) - $signed({1'b0, mag});
        end
        if (acc_sum > ACC_MAX) begin
            acc_next = ACC_MAX[47:0];
        end else if (acc_sum < ACC_MIN) begin
            acc_next = ACC_MIN[47:0];
        end else begin
            acc_next = acc_sum[47:0];
        end
    end

    // Payload and working registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                idx_reg  <= s_atom_index;
                pix_reg  <= s_pos_i_x;
                piy_reg  <= s_pos_i_y;
                piz_reg  <= s_pos_i_z;
                pjx_reg  <= s_pos_j_x;
                pjy_reg  <= s_pos_j_y;
                pjz_reg  <= s_pos_j_z;
                last_reg <= s_last_pair;
                p1_reg   <= s_charge_i * s_dcharge_j;
                p2_reg   <= s_dcharge_i * s_charge_j;
            end
            OP_AXIS: begin
                axis_reg[cmd.sel] <= axis_prod[63:32];
                coef_reg          <= 49'(p1_reg) + 49'(p2_reg);
            end
            OP_SQUARE: begin
                r2_reg   <= ((cmd.sel == 2'd0) ? 64'd0 : r2_reg) + sq;
                neg_reg  <= coef_reg[48];
                cmag_reg <= coef_reg[48] ? 48'(-coef_reg) : coef_reg[47:0];
            end
            OP_SQRT_INIT: begin
                v_reg   <= r2_reg;
                res_reg <= '0;
                bit_reg <= 64'd1 << 62;
            end
            OP_SQRT_STEP: begin
                if (v_reg >= sum_rb) begin
                    v_reg   <= v_reg - sum_rb;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end else begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            OP_BETA: x_reg <= beta_prod[63:20];
            OP_ROM_LO: rom_q_reg <= ERF_TAB[rom_addr];
            OP_ROM_HI: begin
                t0_reg    <= rom_q_reg;
                rom_q_reg <= ERF_TAB[rom_addr];
            end
            OP_INTERP: begin
                rem_reg <= '0;
                nq_reg  <= {erf_val, 24'd0};
            end
            OP_DIV_STEP: begin
                rem_reg <= div_ge ? 32'(div_t - {1'b0, res_reg[31:0]}) : div_t[31:0];
                nq_reg  <= {nq_reg[53:0], div_ge};
            end
            OP_MUL: prod_reg <= ((cmd.sel == 2'd0) ? 102'd0 : prod_reg) + pp_shift;
            OP_EMIT: begin
                out_idx_reg    <= idx_reg;
                out_energy_reg <= acc_reg;
            end
            default: ;
        endcase
    end

    // Accumulator and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.op == OP_ACC) begin
                acc_reg <= acc_next;
            end else if (cmd.op == OP_EMIT) begin
                acc_reg <= '0;
            end
            if (cmd.op == OP_EMIT) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign status.r_zero    = (res_reg == 64'd0);
    assign status.last      = last_reg;
    assign status.out_full  = m_valid_reg && !m_ready;
    assign m_valid          = m_valid_reg;
    assign m_atom_index_out = out_idx_reg;
    assign m_atom_energy    = out_energy_reg;

endmodule

// File: hw/rtl/ewald_excluded_pair_cross_energy.sv
// Excluded-pair Ewald cross energy correction, top level.
// Takes one transaction at a time: s_ready is high only while the sequencer is idle.
// A zero distance skips the erf lookup and divide, and a last pair waits in finish while
// a result is still held; the bit-serial root and the restoring divider set the pace.
// Synchronous active-low reset clears the accumulator, result valid and the sequencer;
// box lengths reset to zero and beta to its default.
`timescale 1ns / 1ps
module ewald_excluded_pair_cross_energy (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [eepce_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                      cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [15:0]                      s_atom_index,
    input  logic [31:0]                      s_pos_i_x,
    input  logic [31:0]                      s_pos_i_y,
    input  logic [31:0]                      s_pos_i_z,
    input  logic signed [23:0]               s_charge_i,
    input  logic signed [23:0]               s_dcharge_i,
    input  logic [31:0]                      s_pos_j_x,
    input  logic [31:0]                      s_pos_j_y,
    input  logic [31:0]                      s_pos_j_z,
    input  logic signed [23:0]               s_charge_j,
    input  logic signed [23:0]               s_dcharge_j,
    input  logic                             s_last_pair,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [15:0]                      m_atom_index_out,
    output logic signed [47:0]               m_atom_energy
);
    import eepce_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencer
    eepce_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Arithmetic and storage
    eepce_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_atom_index     (s_atom_index),
        .s_pos_i_x        (s_pos_i_x),
        .s_pos_i_y        (s_pos_i_y),
        .s_pos_i_z        (s_pos_i_z),
        .s_charge_i       (s_charge_i),
        .s_dcharge_i      (s_dcharge_i),
        .s_pos_j_x        (s_pos_j_x),
        .s_pos_j_y        (s_pos_j_y),
        .s_pos_j_z        (s_pos_j_z),
        .s_charge_j       (s_charge_j),
        .s_dcharge_j      (s_dcharge_j),
        .s_last_pair      (s_last_pair),
        .cmd              (cmd),
        .status           (status),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_atom_index_out (m_atom_index_out),
        .m_atom_energy    (m_atom_energy)
    );

endmodule

// File: test/tb.sv
// Self-checking testbench for ewald_excluded_pair_cross_energy.
// Drives excluded pairs, predicts the per-atom saturated energy totals and checks
// every result transaction. Depends on eepce_pkg and the top-level RTL.
`timescale 1ns / 1ps
module tb;
    import eepce_pkg::*;

    localparam int          RUN_LIMIT   = 3000000;
    localparam int          DRAIN_WAIT  = 150;
    localparam int          STALL_LEN   = 3000;
    localparam logic [7:0]  REG_SPARE_A = 8'd4;
    localparam logic [7:0]  REG_SPARE_B = 8'hFF;
    localparam logic [63:0] TERM_CAP    = 64'd1 << 48;
    localparam logic [31:0] ONE_ANG     = 32'd1 << 24;

    typedef struct packed {
        logic [15:0]        atom;
        logic [31:0]        pix, piy, piz;
        logic signed [23:0] ci, dci;
        logic [31:0]        pjx, pjy, pjz;
        logic signed [23:0] cj, dcj;
        logic               last;
    } pair_t;

    typedef struct packed {
        logic [15:0] atom;
        logic [47:0] energy;
    } total_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [15:0] m_atom_index_out;
    logic signed [47:0] m_atom_energy;
    pair_t s_item = '0;

    // Stimulus queues, shadow registers and predictor state
    pair_t  pending_q[$];
    total_t totals_q[$];
    logic [31:0] box_x, box_y, box_z, beta;
    logic [31:0] erf_lut [0:ERF_N];
    longint energy_sum;
    logic [15:0] cur_atom;
    bit   s_took;
    int   tx_idle, rx_idle;
    int   errors, cycles;
    int   hold_req, hold_seen, hold_left;

    ewald_excluded_pair_cross_energy DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_atom_index(s_item.atom),
        .s_pos_i_x(s_item.pix), .s_pos_i_y(s_item.piy), .s_pos_i_z(s_item.piz),
        .s_charge_i(s_item.ci), .s_dcharge_i(s_item.dci),
        .s_pos_j_x(s_item.pjx), .s_pos_j_y(s_item.pjy), .s_pos_j_z(s_item.pjz),
        .s_charge_j(s_item.cj), .s_dcharge_j(s_item.dcj),
        .s_last_pair(s_item.last),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_atom_index_out(m_atom_index_out), .m_atom_energy(m_atom_energy)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // exp(-y): y in Q.32, result Q1.31; Taylor of exp(-y/64) squared six times
    function automatic logic [63:0] exp_decay(input logic [63:0] y);
        logic [63:0] z;
        logic [63:0] r;
        int k;
        if (y >= (64'd32 << 32)) return 64'd0;
        z = y >> 7;
        r = 64'd1 << 31;
        for (k = 8; k >= 1; k--) r = (64'd1 << 31) - (((z * r) >> 31) / 64'(k));
        for (k = 0; k < 6; k++) r = (r * r) >> 31;
        return r;
    endfunction

    // Build the erf samples by trapezoid integration of the Gaussian
    task automatic build_erf_lut();
        logic [63:0] n, s, gprev, t, g, v, e;
        int m;
        n = 64'(ERF_N) * 16;
        s = 0;
        gprev = 64'd1 << 31;
        erf_lut[0] = 32'd0;
        for (m = 1; m <= ERF_N * 16; m++) begin
            t = (64'(m) << 31) / n;
            g = exp_decay((t * t) >> 24);
            s = s + gprev + g;
            gprev = g;
            if (m % 16 == 0) begin
                v = (s << 8) / n;
                e = (v * 64'd9465531) >> 30;
                if (e > ONE_Q30) e = ONE_Q30;
                erf_lut[m / 16] = e[31:0];
            end
        end
    endtask

    function automatic logic [63:0] axis_len(input logic [31:0] box, input logic [31:0] pj,
                                             input logic [31:0] pi);
        logic [31:0] d;
        logic [31:0] mag;
        d = pj - pi;
        mag = d[31] ? -d : d;
        return (64'(box) * 64'(mag)) >> 32;
    endfunction

    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Accumulate one pair's correction; return 1 with the atom total on its last pair
    function automatic bit accumulate_pair(input pair_t p, output total_t tot);
        logic [63:0] dx, dy, dz, r, x, pos, idx, erf, ratio, cmag, mag, t0, t1, frac;
        logic [127:0] prod;
        longint coef;
        dx = axis_len(box_x, p.pjx, p.pix);
        dy = axis_len(box_y, p.pjy, p.piy);
        dz = axis_len(box_z, p.pjz, p.piz);
        r = root_floor(dx * dx + dy * dy + dz * dz);
        if (r != 0) begin
            x = (64'(beta) * r) >> 20;
            pos = x * 64'(ERF_N);
            idx = pos >> 35;
            if (idx >= 64'(ERF_N)) begin
                erf = ONE_Q30;
            end else begin
                frac = 64'(pos[34:19]);
                t0 = 64'(erf_lut[idx]);
                t1 = 64'(erf_lut[idx + 1]);
                erf = (t1 >= t0) ? t0 + (((t1 - t0) * frac) >> 16)
                                 : t0 - (((t0 - t1) * frac) >> 16);
            end
            ratio = (erf << 24) / r;
            coef = longint'(p.ci) * longint'(p.dcj) + longint'(p.dci) * longint'(p.cj);
            cmag = (coef < 0) ? 64'(-coef) : 64'(coef);
            prod = 128'(cmag) * 128'(ratio);
            mag = (|prod[127:102]) ? TERM_CAP : prod[101:38];
            if (mag > TERM_CAP) mag = TERM_CAP;
            if (coef < 0) energy_sum = energy_sum + longint'(mag);
            else energy_sum = energy_sum - longint'(mag);
            if (energy_sum > longint'(ACC_MAX)) energy_sum = longint'(ACC_MAX);
            if (energy_sum < longint'(ACC_MIN)) energy_sum = longint'(ACC_MIN);
        end
        tot = '0;
        if (p.last) begin
            tot.atom = p.atom;
            tot.energy = energy_sum[47:0];
            energy_sum = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        if (errors < 40)
            $display("tb: mismatch on %s: got %0h, expected %0h (cycle %0d)",
                     what, got, want, cycles);
        errors++;
    endtask

    // Driver: hold a transaction until accepted, then offer the next or idle
    always @(negedge aclk) begin : driver
        pair_t p;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_took) begin
            s_took = 1'b0;
            if (pending_q.size() != 0 && $urandom_range(99) >= tx_idle) begin
                p = pending_q.pop_front();
                s_item <= p;
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= STALL_LEN;
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn && ($urandom_range(99) >= rx_idle);
        end
    end

    // Monitor: predict on input transactions, check result transactions
    always @(posedge aclk) begin : monitor
        total_t t;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                if (accumulate_pair(s_item, t)) totals_q.push_back(t);
                s_took = 1'b1;
            end
            if (m_valid && m_ready) begin
                if (totals_q.size() == 0) begin
                    report("unexpected result", 64'(m_atom_energy), 64'd0);
                end else begin
                    t = totals_q.pop_front();
                    if (m_atom_index_out !== t.atom)
                        report("atom_index_out", 64'(m_atom_index_out), 64'(t.atom));
                    if (m_atom_energy !== t.energy)
                        report("atom_energy", 64'(m_atom_energy), 64'(t.energy));
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_BOX_X: box_x = val;
            REG_BOX_Y: box_y = val;
            REG_BOX_Z: box_z = val;
            REG_BETA:  beta = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [31:0] bx, input logic [31:0] by,
                              input logic [31:0] bz, input logic [31:0] bb);
        write_reg(REG_BOX_X, bx);
        write_reg(REG_BOX_Y, by);
        write_reg(REG_BOX_Z, bz);
        write_reg(REG_BETA, bb);
        write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
    endtask

    // Wait until the block is idle: nothing queued, offered or expected
    task automatic drain();
        while (pending_q.size() != 0 || s_valid || totals_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    function automatic pair_t mk_pair(input logic [15:0] atom, input logic [31:0] pi,
                                      input logic [31:0] pj, input logic signed [23:0] ci,
                                      input logic signed [23:0] dci,
                                      input logic signed [23:0] cj,
                                      input logic signed [23:0] dcj, input logic last);
        pair_t p;
        p.atom = atom;
        p.pix = pi; p.piy = pi; p.piz = pi;
        p.pjx = pj; p.pjy = pj; p.pjz = pj;
        p.ci = ci; p.dci = dci; p.cj = cj; p.dcj = dcj;
        p.last = last;
        return p;
    endfunction

    function automatic logic [31:0] rand_delta();
        logic [31:0] d;
        int sh;
        case ($urandom_range(5))
            0: d = $urandom;
            1: d = 32'd0;
            default: begin
                sh = $urandom_range(31);
                d = $urandom & ((32'd1 << sh) - 1);
                if ($urandom_range(1)) d = -d;
            end
        endcase
        return d;
    endfunction

    function automatic logic signed [23:0] rand_charge();
        if ($urandom_range(3) == 0) return 24'($urandom);
        return 24'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
    endfunction

    // Mostly runs of pairs for one atom; now and then a stray atom index
    function automatic pair_t rand_pair();
        pair_t p;
        p.pix = $urandom; p.piy = $urandom; p.piz = $urandom;
        p.pjx = p.pix + rand_delta();
        p.pjy = p.piy + rand_delta();
        p.pjz = p.piz + rand_delta();
        p.ci = rand_charge(); p.dci = rand_charge();
        p.cj = rand_charge(); p.dcj = rand_charge();
        p.last = ($urandom_range(3) == 0);
        p.atom = ($urandom_range(15) == 0) ? 16'($urandom) : cur_atom;
        if (p.last) cur_atom = 16'($urandom);
        return p;
    endfunction

    initial begin : stimulus
        logic signed [23:0] qmax, qmin;
        int ph, k;
        qmax = 24'sh7FFFFF;
        qmin = 24'sh800000;
        build_erf_lut();
        box_x = 0; box_y = 0; box_z = 0; beta = BETA_RESET;
        energy_sum = 0;
        cur_atom = 16'd7;
        tx_idle = 11; rx_idle = 74;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        // Reset settings: zero box, so every pair has zero distance
        pending_q.push_back(mk_pair(16'hFFFF, 32'hFFFFFFFF, 32'h0, qmax, qmin, qmax, qmin, 0));
        pending_q.push_back(mk_pair(16'hFFFF, 32'h0, 32'hFFFFFFFF, qmin, qmax, qmin, qmax, 1));
        pending_q.push_back(mk_pair(16'h0, 32'h12345678, 32'h87654321, qmax, qmax, 0, 0, 1));
        drain();

        // Typical box: zero distance, wrap extremes and mixed atom indices
        set_config(40 * ONE_ANG, 40 * ONE_ANG, 40 * ONE_ANG, BETA_RESET);
        pending_q.push_back(mk_pair(16'd3, 32'hA5A5A5A5, 32'hA5A5A5A5, qmax, qmax, qmax, qmax, 1));
        pending_q.push_back(mk_pair(16'd4, 32'h0, 32'hFFFFFFFF, qmax, qmax, qmax, qmax, 0));
        pending_q.push_back(mk_pair(16'd4, 32'h0, 32'h80000000, qmin, qmax, 24'sd65536, 24'sd1, 0));
        pending_q.push_back(mk_pair(16'd9, 32'h100, 32'h01000100, 24'sd65536, 24'sd3000,
                                    -24'sd65536, 24'sd9000, 0));
        pending_q.push_back(mk_pair(16'd4, 32'h7FFFFFFF, 32'h80000000, qmin, qmin, qmin, qmin, 1));
        drain();

        // Tiny box and maximum beta: drive both atom totals into the negative saturation limit
        set_config(ONE_ANG, ONE_ANG, ONE_ANG, 32'hFFFFFFFF);
        for (k = 0; k < 17; k++)
            pending_q.push_back(mk_pair(16'd21, 32'h0, 32'h04000000, qmax, qmax, qmax, qmax,
                                        k == 16));
        for (k = 0; k < 17; k++)
            pending_q.push_back(mk_pair(16'd22, 32'h0, 32'h04000000, qmax, qmin, qmin, qmax,
                                        k == 16));
        // Half an angstrom along each axis at maximum beta lies beyond the erf table
        pending_q.push_back(mk_pair(16'd23, 32'h0, 32'h80000000, 24'sd65536, 24'sd65536,
                                    24'sd65536, 24'sd65536, 1));
        drain();

        // Random part over several settings and idle patterns
        for (ph = 0; ph < 5; ph++) begin
            case (ph)
                0: set_config(40 * ONE_ANG, 40 * ONE_ANG, 40 * ONE_ANG, BETA_RESET);
                1: set_config($urandom, $urandom, $urandom, $urandom);
                2: set_config(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
                3: set_config(32'd0, 2 * ONE_ANG, $urandom, 32'd0);
                default: set_config($urandom_range(1, 4) * ONE_ANG, $urandom_range(1, 4) * ONE_ANG,
                                    $urandom_range(1, 4) * ONE_ANG, $urandom);
            endcase
            if (ph < 2) begin
                tx_idle = 11; rx_idle = 74;
            end else if (ph < 4) begin
                tx_idle = 74; rx_idle = 11;
            end else begin
                tx_idle = 0; rx_idle = 0;
            end
            for (k = 0; k < 310; k++) pending_q.push_back(rand_pair());
            // Close any open atom so the phase ends on a result
            pending_q.push_back(mk_pair(cur_atom, $urandom, $urandom, rand_charge(),
                                        rand_charge(), rand_charge(), rand_charge(), 1));
            if (ph == 4) hold_req++;
            drain();
        end

        if (errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/eepce_pkg.sv
hw/rtl/eepce_ctrl.sv
hw/rtl/eepce_datapath.sv
hw/rtl/ewald_excluded_pair_cross_energy.sv
test/tb.sv
